FILE: rtl/stdr_pkg.sv
// Shared types and constants of the scanline triangle depth rasterizer.
// Used by the controller, the divider, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package stdr_pkg;

  localparam int XW = 12;   // screen coordinate width
  localparam int ZW = 24;   // depth width, Q8.16
  localparam int AW = 25;   // multiplicand width (depth difference)
  localparam int BW = 13;   // multiplier width (row or column offset)
  localparam int PW = 38;   // signed product width
  localparam int NW = 37;   // product magnitude width
  localparam int DW = 12;   // divisor width
  localparam int QW = 27;   // rounded quotient width
  localparam int SW = 28;   // base plus quotient width

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic                 command;
    logic signed [11:0]   x0;
    logic signed [11:0]   y0;
    logic signed [23:0]   z0;
    logic signed [11:0]   x1;
    logic signed [11:0]   y1;
    logic signed [23:0]   z1;
    logic signed [11:0]   x2;
    logic signed [11:0]   y2;
    logic signed [23:0]   z2;
  } item_t;

  typedef struct packed {
    logic signed [11:0]   pixel_x;
    logic signed [11:0]   pixel_y;
    logic signed [23:0]   depth;
    logic                 depth_pass;
    logic                 off_frame;
    logic                 last_pixel;
  } result_t;

  // interpolation job run through the shared multiply and divide
  typedef enum logic [2:0] {
    OP_XA  = 3'd0,
    OP_ZA  = 3'd1,
    OP_XB  = 3'd2,
    OP_ZB  = 3'd3,
    OP_PIX = 3'd4
  } op_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic mul_en;
    logic div_start;
    logic capture;
    logic span_set;
    logic pix_zero;
    logic addr_en;
    logic rd_en;
    logic wr_en;
    op_t  op;
  } ctl_t;

  typedef struct packed {
    logic clear_last;
    logic flat;
    logic single;
    logic at_right;
    logic row_last;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/stdr_div.sv
// Radix-2 restoring divider with round half away from zero.
// Depends on stdr_pkg for widths.
`timescale 1ns / 1ps
module stdr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [stdr_pkg::NW-1:0]     num,
  input  logic                        neg,
  input  logic [stdr_pkg::DW-1:0]     den,
  output logic                        done,
  output logic signed [stdr_pkg::QW-1:0] quo
);

  logic [stdr_pkg::NW-1:0] q;
  logic [stdr_pkg::DW-1:0] rem;
  logic [stdr_pkg::DW-1:0] dv;
  logic                    sgn;
  logic [5:0]              cnt;
  logic                    run;
  logic [stdr_pkg::DW:0]   rem_sh;
  logic                    fits;
  logic [stdr_pkg::QW-1:0] q_rnd;

  // trial subtract of the next bit
  assign rem_sh = {rem, q[stdr_pkg::NW-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  // control: iterate one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'(stdr_pkg::NW);
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift quotient in, hold remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dv  <= den;
      sgn <= neg;
    end else if (run) begin
      if (fits) begin
        rem <= stdr_pkg::DW'(rem_sh - {1'b0, dv});
      end else begin
        rem <= rem_sh[stdr_pkg::DW-1:0];
      end
      q <= {q[stdr_pkg::NW-2:0], fits};
    end
  end

  // round up when twice the remainder reaches the divisor
  assign q_rnd = stdr_pkg::QW'(q) +
                 stdr_pkg::QW'(({rem, 1'b0} >= {1'b0, dv}) ? 1 : 0);
  assign quo   = sgn ? -$signed(q_rnd) : $signed(q_rnd);

endmodule

FILE: rtl/stdr_datapath.sv
// Datapath: sorted vertices, span registers, shared multiply/divide and depth store.
// Depends on stdr_pkg and stdr_div.
`timescale 1ns / 1ps
module stdr_datapath #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 1024,
  parameter int DEPTH_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  stdr_pkg::item_t     item,
  input  stdr_pkg::ctl_t      ctl,
  output stdr_pkg::sts_t      sts,
  output stdr_pkg::result_t   result,
  output logic                strobe
);

  localparam int DEPTH_N = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int MAW     = $clog2(DEPTH_N);
  localparam logic signed [32:0] ZMIN = -(33'sd1 <<< (DEPTH_BITS - 1));
  localparam logic signed [32:0] ZMAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [23:0] z;
  } vtx_t;

  // depth store and its clearing pass
  logic signed [DEPTH_BITS-1:0] mem [DEPTH_N];
  logic [MAW-1:0]               clr_cnt;
  logic [MAW-1:0]               addr;
  logic signed [DEPTH_BITS-1:0] rd_data;
  logic signed [DEPTH_BITS-1:0] zs;
  logic                         off;

  vtx_t v0, v1, v2;
  vtx_t s0, s1, s2, t0, t1, t2, u0, u1;
  logic [11:0]        row;
  logic signed [11:0] left, right, cur;
  logic signed [23:0] zl, zr;
  logic signed [11:0] xa, xb;
  logic signed [23:0] za, zb;
  logic signed [23:0] pix_z;

  logic [11:0]        hl, ht, hh;
  logic               upper;
  logic signed [11:0] py;

  logic signed [stdr_pkg::AW-1:0] a_mux;
  logic signed [stdr_pkg::BW-1:0] b_mux;
  logic [stdr_pkg::DW-1:0]        d_mux;
  logic signed [stdr_pkg::AW-1:0] base_mux;
  logic signed [stdr_pkg::PW-1:0] prod;
  logic [stdr_pkg::DW-1:0]        den;
  logic signed [stdr_pkg::AW-1:0] base;
  logic [stdr_pkg::NW-1:0]        mag;
  logic                           div_done;
  logic signed [stdr_pkg::QW-1:0] quo;
  logic signed [stdr_pkg::SW-1:0] sum;
  logic signed [32:0]             z_ext;
  logic                           pass;

  // sort the incoming vertices by y with three compare-and-swap stages
  always_comb begin
    s0 = '{x: item.x0, y: item.y0, z: item.z0};
    s1 = '{x: item.x1, y: item.y1, z: item.z1};
    s2 = '{x: item.x2, y: item.y2, z: item.z2};
    if (s0.y > s1.y) begin
      t0 = s1; t1 = s0;
    end else begin
      t0 = s0; t1 = s1;
    end
    if (t1.y > s2.y) begin
      u1 = s2; t2 = t1;
    end else begin
      u1 = t1; t2 = s2;
    end
    if (t0.y > u1.y) begin
      u0 = u1; u1 = t0;
    end else begin
      u0 = t0;
    end
  end

  // edge heights of the sorted triangle
  assign hl    = 12'(v1.y - v0.y);
  assign ht    = 12'(v2.y - v0.y);
  assign hh    = 12'(v2.y - v1.y);
  assign upper = (row > hl) || (hl == 12'd0);
  assign py    = 12'(v0.y + $signed({1'b0, row}));

  // select operands of the current interpolation
  always_comb begin
    a_mux    = '0;
    b_mux    = $signed({1'b0, row});
    d_mux    = ht;
    base_mux = '0;
    unique case (ctl.op)
      stdr_pkg::OP_XA: begin
        a_mux    = stdr_pkg::AW'(v2.x) - stdr_pkg::AW'(v0.x);
        base_mux = stdr_pkg::AW'(v0.x);
      end
      stdr_pkg::OP_ZA: begin
        a_mux    = stdr_pkg::AW'(v2.z) - stdr_pkg::AW'(v0.z);
        base_mux = stdr_pkg::AW'(v0.z);
      end
      stdr_pkg::OP_XB: begin
        if (upper) begin
          a_mux    = stdr_pkg::AW'(v2.x) - stdr_pkg::AW'(v1.x);
          b_mux    = $signed({1'b0, 12'(row - hl)});
          d_mux    = hh;
          base_mux = stdr_pkg::AW'(v1.x);
        end else begin
          a_mux    = stdr_pkg::AW'(v1.x) - stdr_pkg::AW'(v0.x);
          d_mux    = hl;
          base_mux = stdr_pkg::AW'(v0.x);
        end
      end
      stdr_pkg::OP_ZB: begin
        if (upper) begin
          a_mux    = stdr_pkg::AW'(v2.z) - stdr_pkg::AW'(v1.z);
          b_mux    = $signed({1'b0, 12'(row - hl)});
          d_mux    = hh;
          base_mux = stdr_pkg::AW'(v1.z);
        end else begin
          a_mux    = stdr_pkg::AW'(v1.z) - stdr_pkg::AW'(v0.z);
          d_mux    = hl;
          base_mux = stdr_pkg::AW'(v0.z);
        end
      end
      stdr_pkg::OP_PIX: begin
        a_mux    = stdr_pkg::AW'(zr) - stdr_pkg::AW'(zl);
        b_mux    = $signed({1'b0, 12'(cur - left)});
        d_mux    = 12'(right - left);
        base_mux = stdr_pkg::AW'(zl);
      end
      default: begin
        a_mux = '0;
      end
    endcase
  end

  // register the product ahead of the divider
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a_mux * b_mux;
      den  <= d_mux;
      base <= base_mux;
    end
  end

  assign mag = prod[stdr_pkg::PW-1] ? stdr_pkg::NW'(-prod) : stdr_pkg::NW'(prod);

  stdr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (mag),
    .neg   (prod[stdr_pkg::PW-1]),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  assign sum = stdr_pkg::SW'(base) + stdr_pkg::SW'(quo);

  // vertex, span and walk registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v0  <= u0;
      v1  <= u1;
      v2  <= t2;
      row <= '0;
    end
    if (ctl.capture) begin
      unique case (ctl.op)
        stdr_pkg::OP_XA:  xa    <= sum[11:0];
        stdr_pkg::OP_ZA:  za    <= sum[23:0];
        stdr_pkg::OP_XB:  xb    <= sum[11:0];
        stdr_pkg::OP_ZB:  zb    <= sum[23:0];
        stdr_pkg::OP_PIX: pix_z <= sum[23:0];
        default:          pix_z <= sum[23:0];
      endcase
    end
    if (ctl.pix_zero) begin
      pix_z <= '0;
    end
    if (ctl.span_set) begin
      if (xa > xb) begin
        left <= xb; zl <= zb; right <= xa; zr <= za; cur <= xb;
      end else begin
        left <= xa; zl <= za; right <= xb; zr <= zb; cur <= xa;
      end
    end
    if (ctl.wr_en) begin
      if (cur >= right) begin
        row <= row + 12'd1;
      end else begin
        cur <= cur + 12'sd1;
      end
    end
  end

  // saturate to the store width
  always_comb begin
    z_ext = 33'(pix_z);
    if (z_ext < ZMIN) begin
      z_ext = ZMIN;
    end else if (z_ext > ZMAX) begin
      z_ext = ZMAX;
    end
  end

  // form the store address and frame test
  always_ff @(posedge clk) begin
    if (ctl.addr_en) begin
      addr <= MAW'(32'({1'b0, py[10:0]}) * FRAME_WIDTH + 32'({1'b0, cur[10:0]}));
      off  <= cur[11] || ({1'b0, cur} >= 13'(FRAME_WIDTH)) ||
              py[11]  || ({1'b0, py}  >= 13'(FRAME_HEIGHT));
      zs   <= DEPTH_BITS'(z_ext);
    end
  end

  assign pass = !off && (zs > rd_data);

  // clear counter for the pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear_en) begin
      clr_cnt <= clr_cnt + MAW'(1);
    end
  end

  // depth store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clear_en) begin
      mem[clr_cnt] <= DEPTH_BITS'(ZMIN);
    end else if (ctl.wr_en && pass) begin
      mem[addr] <= zs;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

  // result register, shown for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      result.pixel_x    <= cur;
      result.pixel_y    <= py;
      result.depth      <= pix_z;
      result.depth_pass <= pass;
      result.off_frame  <= off;
      result.last_pixel <= sts.at_right && sts.row_last;
    end
  end

  // status back to the controller
  assign sts.clear_last = clr_cnt == MAW'(DEPTH_N - 1);
  assign sts.flat       = v2.y == v0.y;
  assign sts.single     = left == right;
  assign sts.at_right   = cur >= right;
  assign sts.row_last   = (13'(row) + 13'd1) >= 13'(ht);
  assign sts.div_done   = div_done;

endmodule

FILE: rtl/stdr_ctrl.sv
// Controller: sequences clearing, triangle setup and per-pixel steps.
// Depends on stdr_pkg.
`timescale 1ns / 1ps
module stdr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             command,
  input  stdr_pkg::sts_t   sts,
  output stdr_pkg::ctl_t   ctl,
  output logic             busy
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_LOADCHK = 10'b0000000100,
    S_MUL     = 10'b0000001000,
    S_DIVGO   = 10'b0000010000,
    S_DIVWAIT = 10'b0000100000,
    S_SPAN    = 10'b0001000000,
    S_ADR     = 10'b0010000000,
    S_RD      = 10'b0100000000,
    S_WR      = 10'b1000000000
  } state_t;

  state_t          state, state_next;
  stdr_pkg::op_t   op, op_next;
  logic            walk, walk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op    <= stdr_pkg::OP_XA;
      walk  <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      walk  <= walk_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    op_next    = op;
    walk_next  = walk;
    ctl        = '0;
    ctl.op     = op;
    unique case (state)
      S_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (command == stdr_pkg::CMD_LOAD) begin
            ctl.load   = 1'b1;
            state_next = S_LOADCHK;
          end else if (walk) begin
            if (sts.single) begin
              ctl.pix_zero = 1'b1;
              state_next   = S_ADR;
            end else begin
              op_next    = stdr_pkg::OP_PIX;
              state_next = S_MUL;
            end
          end
        end
      end
      S_LOADCHK: begin
        walk_next = !sts.flat;
        if (sts.flat) begin
          state_next = S_IDLE;
        end else begin
          op_next    = stdr_pkg::OP_XA;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        ctl.div_start = 1'b1;
        state_next    = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (sts.div_done) begin
          ctl.capture = 1'b1;
          unique case (op)
            stdr_pkg::OP_XA:  begin op_next = stdr_pkg::OP_ZA; state_next = S_MUL; end
            stdr_pkg::OP_ZA:  begin op_next = stdr_pkg::OP_XB; state_next = S_MUL; end
            stdr_pkg::OP_XB:  begin op_next = stdr_pkg::OP_ZB; state_next = S_MUL; end
            stdr_pkg::OP_ZB:  state_next = S_SPAN;
            stdr_pkg::OP_PIX: state_next = S_ADR;
            default:          state_next = S_IDLE;
          endcase
        end
      end
      S_SPAN: begin
        ctl.span_set = 1'b1;
        state_next   = S_IDLE;
      end
      S_ADR: begin
        ctl.addr_en = 1'b1;
        state_next  = S_RD;
      end
      S_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        ctl.wr_en = 1'b1;
        if (sts.at_right && sts.row_last) begin
          walk_next  = 1'b0;
          state_next = S_IDLE;
        end else if (sts.at_right) begin
          op_next    = stdr_pkg::OP_XA;
          state_next = S_MUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;

`ifndef SYNTHESIS
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && command == stdr_pkg::CMD_STEP && !walk) |=> state == S_IDLE)
    else $error("step while idle left the idle state");
  a_div_seq: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> state == S_DIVWAIT)
    else $error("divider start not followed by wait");
  a_wr_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> walk)
    else $error("pixel written outside a walk");
  a_span_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_SPAN |=> state == S_IDLE)
    else $error("span setup did not return to idle");
`endif

endmodule

FILE: rtl/scanline_triangle_depth_raster.sv
// Top level of the scanline triangle depth rasterizer.
// Instantiates stdr_ctrl and stdr_datapath; uses stdr_pkg types.
`timescale 1ns / 1ps

// A command is transferred when start is high and busy is low. After reset the
// depth store is cleared to its minimum, one entry a cycle, while busy stays
// high. Each interpolation runs through one multiplier and a one-bit-a-cycle
// divider. A load of a flat triangle keeps busy high only for the check.
// Any other load keeps it high for the check, four interpolations for the first
// span and the span setup. A step keeps busy high for one interpolation, then
// address, store read and write. A step on a one-pixel span skips the
// interpolation. The step that ends a row other than the last also sets up
// the next span. Each result is on the result port for one cycle with strobe
// high and must be taken then.
module scanline_triangle_depth_raster #(
  parameter int FRAME_WIDTH  = 1024,
  parameter int FRAME_HEIGHT = 1024,
  parameter int DEPTH_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  stdr_pkg::item_t     item,
  output stdr_pkg::result_t   result,
  output logic                strobe
);

  stdr_pkg::ctl_t ctl;
  stdr_pkg::sts_t sts;

  stdr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  stdr_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .DEPTH_BITS   (DEPTH_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctl    (ctl),
    .sts    (sts),
    .result (result),
    .strobe (strobe)
  );

endmodule
